@@ hw/rtl/eqp_pkg.sv @@
// Shared constants, configuration codes and controller/datapath interface types.
`default_nettype none

package eqp_pkg;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int WINDOW_MAX_DEF   = 64;

  // field widths
  localparam int WS_W     = 7;
  localparam int RECIP_W  = 16;
  localparam int LPV_W    = 18;
  localparam int HPV_W    = 24;
  localparam int AVG_W    = 48;
  localparam int SQ_W     = 47;
  localparam int RECIP_FRAC = 16;

  // filter geometry
  localparam int LP_DELAY_A  = 6;
  localparam int LP_DELAY_B  = 12;
  localparam int HP_DELAY    = 32;
  localparam int HP_CENTER   = 16;
  localparam int HP_SHIFT    = 5;
  localparam int SLOPE_SHIFT = 3;
  localparam int SLOPE_TAPS  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RECIP = 1'b1;

  localparam logic [WS_W-1:0]    WS_RESET    = 7'd30;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd2185;

  typedef struct packed {
    logic load_in;
    logic calc_lp;
    logic calc_hp;
    logic calc_slope;
    logic calc_sq;
    logic rb_init;
    logic rb_step;
    logic upd_sum;
    logic calc_avg;
    logic commit;
  } eqp_cmd_t;

  typedef struct packed {
    logic dirty;
    logic rb_done;
  } eqp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ecg_qrs_preprocess_chain_unit.sv @@
// Top level of the QRS preprocessing chain: config registers, sequencer, datapath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   sample_i, end_of_record_i
//   out      source     out_valid_o/out_stall_i lowpass/highpass/slope/integrated_value_o, last_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample is accepted in the idle state and then passes through seven sequencer steps
// (low-pass, high-pass, derivative, square, window update, reciprocal multiply, output).
// The first sample after a window_size write also re-sums the window, between the square
// and window update steps, through the single read port of the ring memory.
// Reset clears all histories; the ring memory is cleared through its valid bits.
// A stalled result holds only the output step; the next sample is taken as soon as the
// previous one has moved into the output register.
`default_nettype none

module ecg_qrs_preprocess_chain_unit
  import eqp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                           end_of_record_i,

  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed      [LPV_W-1:0]        lowpass_value_o,
  output logic signed      [HPV_W-1:0]        highpass_value_o,
  output logic signed      [HPV_W-1:0]        slope_value_o,
  output logic             [AVG_W-1:0]        integrated_value_o,
  output logic                                last_o,

  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic        [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic        [CFG_DATA_W-1:0]   cfg_data_i
);

  logic [WS_W-1:0]    ws_q;
  logic [RECIP_W-1:0] recip_q;
  logic               cfg_wr;
  logic               ws_wr;
  eqp_cmd_t           cmd;
  eqp_sts_t           sts;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign ws_wr       = cfg_wr && (cfg_index_i == CFG_WINDOW_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= WS_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_WINDOW_SIZE:  ws_q    <= cfg_data_i[WS_W-1:0];
        CFG_WINDOW_RECIP: recip_q <= cfg_data_i[RECIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  eqp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eqp_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WINDOW_MAX   (WINDOW_MAX)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sample_i           (sample_i),
    .end_of_record_i    (end_of_record_i),
    .window_size_i      (ws_q),
    .window_recip_i     (recip_q),
    .ws_wr_i            (ws_wr),
    .lowpass_value_o    (lowpass_value_o),
    .highpass_value_o   (highpass_value_o),
    .slope_value_o      (slope_value_o),
    .integrated_value_o (integrated_value_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/eqp_win.sv @@
// Ring memory of squared slopes with per-entry valid bits and registered read.
`default_nettype none

module eqp_win #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 47
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DW-1:0]    rdata_q;
  logic             rok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rok_q   <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rok_q <= valid_q[raddr_i];
      end
    end
  end

  // never-written entries read as zero
  assign rdata_o = rok_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/eqp_ctrl.sv @@
// Sequencer: steps one sample through the datapath and owns the handshakes.
`default_nettype none

module eqp_ctrl
  import eqp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire eqp_sts_t sts_i,
  output eqp_cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LP    = 4'd1;
  localparam logic [3:0] ST_HP    = 4'd2;
  localparam logic [3:0] ST_SLOPE = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_RB    = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_AVG   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_LP;
        end
      end
      ST_LP: begin
        cmd_o.calc_lp = 1'b1;
        state_d       = ST_HP;
      end
      ST_HP: begin
        cmd_o.calc_hp = 1'b1;
        state_d       = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd_o.calc_slope = 1'b1;
        state_d          = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.calc_sq = 1'b1;
        // window length changed since last sample: re-sum from the ring
        if (sts_i.dirty) begin
          cmd_o.rb_init = 1'b1;
          state_d       = ST_RB;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_RB: begin
        cmd_o.rb_step = 1'b1;
        if (sts_i.rb_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.upd_sum = 1'b1;
        state_d       = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.calc_avg = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/eqp_dp.sv @@
// Datapath: filter histories, derivative, squarer, window sum and averaging.
`default_nettype none

module eqp_dp
  import eqp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire eqp_cmd_t                       cmd_i,
  output eqp_sts_t                            sts_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                           end_of_record_i,
  input  wire logic        [WS_W-1:0]         window_size_i,
  input  wire logic        [RECIP_W-1:0]      window_recip_i,
  input  wire logic                           ws_wr_i,
  output logic signed      [LPV_W-1:0]        lowpass_value_o,
  output logic signed      [HPV_W-1:0]        highpass_value_o,
  output logic signed      [HPV_W-1:0]        slope_value_o,
  output logic             [AVG_W-1:0]        integrated_value_o,
  output logic                                last_o
);

  // low-pass gain is 36, so SAMPLE_WIDTH + 6 bits hold it exactly
  localparam int LPW  = SAMPLE_WIDTH + 6;
  localparam int LPX  = LPW + 3;
  localparam int HW   = (LPW + 7 > 28) ? LPW + 7 : 28;
  localparam int DW   = HPV_W + 3;
  localparam int PW   = $clog2(WINDOW_MAX);
  localparam int NW   = $clog2(WINDOW_MAX + 1);
  localparam int SUMW = SQ_W + NW;

  localparam logic signed [HW-1:0] HP_HI = HW'((1 << (HPV_W - 1)) - 1);
  localparam logic signed [HW-1:0] HP_LO = HW'(-(1 << (HPV_W - 1)));
  localparam logic signed [DW-1:0] SL_HI = DW'((1 << (HPV_W - 1)) - 1);
  localparam logic signed [DW-1:0] SL_LO = DW'(-(1 << (HPV_W - 1)));
  localparam int LPV_HI = (1 << (LPV_W - 1)) - 1;
  localparam int LPV_LO = -(1 << (LPV_W - 1));

  // per-sample working registers
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic                           eor_q;
  logic signed [LPW-1:0]          lp_q;
  logic signed [HPV_W-1:0]        hp_q;
  logic signed [HPV_W-1:0]        slope_q;
  logic        [SQ_W-1:0]         sq_q;
  logic        [SUMW-1:0]         ph_q;
  logic        [2*RECIP_W-1:0]    pl_q;

  // histories
  logic signed [SAMPLE_WIDTH-1:0] raw_q [LP_DELAY_B];
  logic signed [LPW-1:0]          lph_q [HP_DELAY];
  logic signed [HPV_W-1:0]        hph_q [SLOPE_TAPS];
  logic        [SUMW-1:0]         sum_q, sum_d;
  logic        [PW-1:0]           pos_q;
  logic        [NW-1:0]           cnt_q;
  logic                           pend_q;
  logic                           dirty_q;

  // output register
  logic signed [LPV_W-1:0] lpv_q;
  logic signed [HPV_W-1:0] hpv_q;
  logic signed [HPV_W-1:0] slv_q;
  logic        [AVG_W-1:0] avg_q;
  logic                    last_q;

  logic signed [LPX-1:0]     lp_full;
  logic signed [LPW-1:0]     lp_d;
  logic signed [HW-1:0]      hp_t;
  logic signed [HW-1:0]      hp_full;
  logic signed [HPV_W-1:0]   hp_d;
  logic signed [DW-1:0]      sl_t;
  logic signed [DW-1:0]      sl_s;
  logic signed [HPV_W-1:0]   slope_d;
  logic signed [2*HPV_W-1:0] sq_full;
  logic        [NW-1:0]      n_eff;
  logic        [NW-1:0]      rd_off;
  logic        [PW:0]        addr_full;
  logic        [PW-1:0]      raddr;
  logic                      rd_en;
  logic        [SQ_W-1:0]    old_sq;
  logic        [SUMW:0]      avg_full;
  logic signed [LPV_W-1:0]   lpv_d;
  logic        [AVG_W-1:0]   avg_d;
  logic                      clr;

  // ---- filters ----
  always_comb begin
    lp_full = (LPX'(lph_q[0]) <<< 1) - LPX'(lph_q[1]) + LPX'(x_q)
            - (LPX'(raw_q[LP_DELAY_A-1]) <<< 1) + LPX'(raw_q[LP_DELAY_B-1]);
    lp_d    = LPW'(lp_full);

    hp_t    = HW'(hph_q[0]) + HW'(lp_q) - HW'(lph_q[HP_DELAY-1]);
    hp_full = (HW'(lph_q[HP_CENTER-1]) <<< HP_SHIFT) - (hp_t >>> HP_SHIFT);
    if (hp_full > HP_HI) begin
      hp_d = HPV_W'(HP_HI);
    end else if (hp_full < HP_LO) begin
      hp_d = HPV_W'(HP_LO);
    end else begin
      hp_d = HPV_W'(hp_full);
    end

    sl_t = (DW'(hph_q[0]) <<< 1) - (DW'(hph_q[2]) <<< 1) - DW'(hph_q[3]) + DW'(hp_q);
    sl_s = sl_t >>> SLOPE_SHIFT;
    if (sl_s > SL_HI) begin
      slope_d = HPV_W'(SL_HI);
    end else if (sl_s < SL_LO) begin
      slope_d = HPV_W'(SL_LO);
    end else begin
      slope_d = HPV_W'(sl_s);
    end

    sq_full = slope_q * slope_q;
  end

  // ---- window addressing ----
  always_comb begin
    if (window_size_i == '0) begin
      n_eff = NW'(1);
    end else if (int'(window_size_i) > WINDOW_MAX) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = NW'(window_size_i);
    end

    // entry leaving the window during a normal update, or the rebuild cursor
    rd_off    = cmd_i.rb_step ? cnt_q : n_eff;
    addr_full = (PW+1)'(pos_q) + (PW+1)'(WINDOW_MAX) - (PW+1)'(rd_off);
    if (addr_full >= (PW+1)'(WINDOW_MAX)) begin
      addr_full = addr_full - (PW+1)'(WINDOW_MAX);
    end
    raddr = addr_full[PW-1:0];
    rd_en = cmd_i.calc_lp || (cmd_i.rb_step && (cnt_q < n_eff));
  end

  assign clr = cmd_i.commit && eor_q;

  eqp_win #(
    .DEPTH (WINDOW_MAX),
    .AW    (PW),
    .DW    (SQ_W)
  ) u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .we_i    (cmd_i.upd_sum),
    .waddr_i (pos_q),
    .wdata_i (sq_q),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (old_sq)
  );

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.rb_init) begin
      sum_d = '0;
    end
    if (cmd_i.rb_step && pend_q) begin
      sum_d = sum_q + SUMW'(old_sq);
    end
    if (cmd_i.upd_sum) begin
      if (dirty_q) begin
        sum_d = sum_q + SUMW'(sq_q);
      end else begin
        sum_d = sum_q + SUMW'(sq_q) - SUMW'(old_sq);
      end
    end
    if (clr) begin
      sum_d = '0;
    end
  end

  // ---- averaging and output formatting ----
  always_comb begin
    avg_full = (SUMW+1)'(ph_q) + (SUMW+1)'(pl_q >> RECIP_FRAC);
    if (avg_full[SUMW:AVG_W] != '0) begin
      avg_d = '1;
    end else begin
      avg_d = avg_full[AVG_W-1:0];
    end

    if (lp_q > LPV_HI) begin
      lpv_d = LPV_W'(LPV_HI);
    end else if (lp_q < LPV_LO) begin
      lpv_d = LPV_W'(LPV_LO);
    end else begin
      lpv_d = LPV_W'(lp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q   <= sample_i;
      eor_q <= end_of_record_i;
    end
    if (cmd_i.calc_lp) begin
      lp_q <= lp_d;
    end
    if (cmd_i.calc_hp) begin
      hp_q <= hp_d;
    end
    if (cmd_i.calc_slope) begin
      slope_q <= slope_d;
    end
    if (cmd_i.calc_sq) begin
      sq_q <= SQ_W'(sq_full);
    end
    if (cmd_i.calc_avg) begin
      ph_q <= SUMW'(sum_q[SUMW-1:RECIP_FRAC] * window_recip_i);
      pl_q <= sum_q[RECIP_FRAC-1:0] * window_recip_i;
    end
    if (cmd_i.commit) begin
      lpv_q  <= lpv_d;
      hpv_q  <= hp_q;
      slv_q  <= slope_q;
      avg_q  <= avg_d;
      last_q <= eor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LP_DELAY_B; i++) raw_q[i] <= '0;
      for (int i = 0; i < HP_DELAY; i++)   lph_q[i] <= '0;
      for (int i = 0; i < SLOPE_TAPS; i++) hph_q[i] <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      sum_q <= sum_d;

      if (cmd_i.rb_init) begin
        cnt_q  <= NW'(1);
        pend_q <= 1'b0;
      end else if (cmd_i.rb_step) begin
        pend_q <= (cnt_q < n_eff);
        if (cnt_q < n_eff) begin
          cnt_q <= cnt_q + NW'(1);
        end
      end

      if (ws_wr_i) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.upd_sum) begin
        dirty_q <= 1'b0;
      end

      if (cmd_i.commit) begin
        if (eor_q) begin
          for (int i = 0; i < LP_DELAY_B; i++) raw_q[i] <= '0;
          for (int i = 0; i < HP_DELAY; i++)   lph_q[i] <= '0;
          for (int i = 0; i < SLOPE_TAPS; i++) hph_q[i] <= '0;
          pos_q <= '0;
        end else begin
          raw_q[0] <= x_q;
          for (int i = 1; i < LP_DELAY_B; i++) raw_q[i] <= raw_q[i-1];
          lph_q[0] <= lp_q;
          for (int i = 1; i < HP_DELAY; i++)   lph_q[i] <= lph_q[i-1];
          hph_q[0] <= hp_q;
          for (int i = 1; i < SLOPE_TAPS; i++) hph_q[i] <= hph_q[i-1];
          if (pos_q == PW'(WINDOW_MAX - 1)) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + PW'(1);
          end
        end
      end
    end
  end

  assign sts_o.dirty   = dirty_q;
  assign sts_o.rb_done = (cnt_q >= n_eff) && !pend_q;

  assign lowpass_value_o    = lpv_q;
  assign highpass_value_o   = hpv_q;
  assign slope_value_o      = slv_q;
  assign integrated_value_o = avg_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

@@ verif/ecg_qrs_preprocess_chain_unit_tb.sv @@
// Self-checking testbench for the QRS preprocessing chain unit.
module ecg_qrs_preprocess_chain_unit_tb;
  import eqp_pkg::*;

  localparam int SW   = SAMPLE_WIDTH_DEF;
  localparam int WMAX = WINDOW_MAX_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 40;

  typedef enum {TX_STREAM, TX_BURSTY} tx_mode_e;
  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum {REC_RANDOM, REC_CARDIAC, REC_SQUARE} rec_style_e;

  typedef struct {
    logic signed [SW-1:0] smp;
    logic                 eor;
  } ecg_beat_t;

  typedef struct {
    logic signed [LPV_W-1:0] lp;
    logic signed [HPV_W-1:0] hp;
    logic signed [HPV_W-1:0] slope;
    logic        [AVG_W-1:0] avg;
    logic                    last;
  } chain_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [SW-1:0]  sample_i = '0;
  logic                  end_of_record_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [LPV_W-1:0] lowpass_value_o;
  logic signed [HPV_W-1:0] highpass_value_o;
  logic signed [HPV_W-1:0] slope_value_o;
  logic [AVG_W-1:0]      integrated_value_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ecg_qrs_preprocess_chain_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .end_of_record_i   (end_of_record_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .lowpass_value_o   (lowpass_value_o),
    .highpass_value_o  (highpass_value_o),
    .slope_value_o     (slope_value_o),
    .integrated_value_o(integrated_value_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // filter state mirror
  logic [WS_W-1:0]    win_size  = WS_RESET;
  logic [RECIP_W-1:0] win_recip = RECIP_RESET;
  longint          raw_hist[12];
  longint          lp_prev[2];
  longint          lp_hist[32];
  longint          hp_prev;
  longint          hp_hist[4];
  longint unsigned sq_ring[WMAX];
  int              ring_pos;

  ecg_beat_t     sample_backlog[$];
  chain_result_t predicted[$];

  tx_mode_e tx_mode = TX_STREAM;
  rx_mode_e rx_mode = RX_FREE;
  bit  sender_hold;
  bit  sample_taken;
  int  burst_left, gap_left;
  int  pat_period = 4, pat_duty = 1, pat_cnt;
  int  hold_token, hold_served, hold_left;
  int  items_queued, beats_in, beats_out, record_ends, reg_writes, mismatches;

  function automatic void clear_histories();
    foreach (raw_hist[k]) raw_hist[k] = 0;
    foreach (lp_prev[k]) lp_prev[k] = 0;
    foreach (lp_hist[k]) lp_hist[k] = 0;
    hp_prev = 0;
    foreach (hp_hist[k]) hp_hist[k] = 0;
    foreach (sq_ring[k]) sq_ring[k] = 0;
    ring_pos = 0;
  endfunction

  function automatic longint clamp_signed(longint v, int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic void predict_chain_outputs(logic signed [SW-1:0] smp, logic eor);
    longint x, lp, acc, hp, slope;
    longint unsigned sq, sum, avg;
    int n;
    chain_result_t r;
    x  = longint'(smp);
    lp = 2 * lp_prev[0] - lp_prev[1] + x - 2 * raw_hist[5] + raw_hist[11];
    acc = hp_prev + lp - lp_hist[31];
    hp  = clamp_signed(32 * lp_hist[15] - (acc >>> HP_SHIFT), HPV_W);
    // five-point derivative centered two samples back
    acc   = hp - hp_hist[3] - 2 * hp_hist[2] + 2 * hp_hist[0];
    slope = clamp_signed(acc >>> SLOPE_SHIFT, HPV_W);
    sq = slope * slope;
    sq_ring[ring_pos] = sq;
    n = (int'(win_size) == 0) ? 1 : (int'(win_size) > WMAX) ? WMAX : int'(win_size);
    sum = 0;
    for (int k = 0; k < n; k++) sum += sq_ring[(ring_pos + WMAX - k) % WMAX];
    ring_pos = (ring_pos + 1) % WMAX;
    avg = (sum >> RECIP_FRAC) * 64'(win_recip)
        + (((sum & 64'hFFFF) * 64'(win_recip)) >> RECIP_FRAC);
    if (avg > 64'hFFFF_FFFF_FFFF) avg = 64'hFFFF_FFFF_FFFF;

    for (int k = 11; k > 0; k--) raw_hist[k] = raw_hist[k-1];
    raw_hist[0] = x;
    lp_prev[1] = lp_prev[0];
    lp_prev[0] = lp;
    for (int k = 31; k > 0; k--) lp_hist[k] = lp_hist[k-1];
    lp_hist[0] = lp;
    hp_prev = hp;
    for (int k = 3; k > 0; k--) hp_hist[k] = hp_hist[k-1];
    hp_hist[0] = hp;

    r.lp    = LPV_W'(clamp_signed(lp, LPV_W));
    r.hp    = HPV_W'(hp);
    r.slope = HPV_W'(slope);
    r.avg   = AVG_W'(avg);
    r.last  = eor;
    predicted.push_back(r);
    if (eor) clear_histories();
  endfunction

  function automatic void compare_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname,
                 $signed(want), $signed(got));
      mismatches++;
    end
  endfunction

  // input accept, config mirror and result check
  always @(posedge clk_i) begin : monitor
    chain_result_t want;
    sample_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WINDOW_SIZE) win_size = cfg_data_i[WS_W-1:0];
        else if (cfg_index_i == CFG_WINDOW_RECIP) win_recip = cfg_data_i;
        reg_writes++;
      end
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (predicted.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result beat with nothing expected, expected none, actual lp=%0d",
                     $time, lowpass_value_o);
          mismatches++;
        end else begin
          want = predicted.pop_front();
          compare_field("lowpass_value", 64'(want.lp), 64'(lowpass_value_o));
          compare_field("highpass_value", 64'(want.hp), 64'(highpass_value_o));
          compare_field("slope_value", 64'(want.slope), 64'(slope_value_o));
          compare_field("integrated_value", 64'(want.avg), 64'(integrated_value_o));
          compare_field("last", 64'(want.last), 64'(last_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_chain_outputs(sample_i, end_of_record_i);
        void'(sample_backlog.pop_front());
        sample_taken = 1'b1;
        beats_in++;
        if (end_of_record_i) record_ends++;
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sample_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sender_hold || sample_backlog.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i      <= 1'b1;
        sample_i        <= sample_backlog[0].smp;
        end_of_record_i <= sample_backlog[0].eor;
        if (tx_mode == TX_BURSTY) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // result receiver stall
  always @(negedge clk_i) begin
    pat_cnt++;
    if (hold_token != hold_served) begin
      hold_served = hold_token;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:    out_stall_i <= 1'b0;
        RX_RANDOM:  out_stall_i <= ($urandom_range(0, 99) < 40);
        default:    out_stall_i <= ((pat_cnt % pat_period) < pat_duty);
      endcase
    end
  end

  function automatic logic signed [SW-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    return r[SW-1:0];
  endfunction

  function automatic void queue_sample(logic signed [SW-1:0] s, logic eor);
    ecg_beat_t b;
    b.smp = s;
    b.eor = eor;
    sample_backlog.push_back(b);
    items_queued++;
  endfunction

  function automatic void queue_record(int len, rec_style_e style);
    int base, period, amp, v;
    logic signed [SW-1:0] s;
    base   = $urandom_range(0, 400) - 200;
    period = $urandom_range(4, 32);
    amp    = $urandom_range(1000, 2047);
    for (int k = 0; k < len; k++) begin
      case (style)
        REC_RANDOM: s = rand_sample();
        REC_CARDIAC: begin
          // baseline with noise and a sharp complex now and then
          v = base + $urandom_range(0, 40) - 20;
          if (k % period == 0) v = v + ($urandom_range(0, 1) ? 1800 : -1800);
          s = v[SW-1:0];
        end
        default: begin
          v = ((k / ((period + 1) / 2)) % 2) ? amp : -amp - 1;
          s = v[SW-1:0];
        end
      endcase
      queue_sample(s, k == len - 1);
    end
  endfunction

  function automatic void queue_mix(int count, bit loud);
    int target, len;
    target = items_queued + count;
    while (items_queued < target) begin
      if (loud) begin
        len = $urandom_range(20, 120);
        if (len > target - items_queued) len = target - items_queued;
        queue_record(len, REC_SQUARE);
      end else if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(4, 100);
        if (len > target - items_queued) len = target - items_queued;
        queue_record(len, rec_style_e'($urandom_range(0, 2)));
      end else begin
        repeat ($urandom_range(1, 6)) queue_sample(rand_sample(), $urandom_range(0, 7) == 0);
      end
    end
  endfunction

  task automatic set_traffic(tx_mode_e tx, rx_mode_e rx);
    tx_mode    = tx;
    rx_mode    = rx;
    pat_period = $urandom_range(3, 20);
    pat_duty   = $urandom_range(1, pat_period - 1);
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || predicted.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(logic [CFG_DATA_W-1:0] size, logic [CFG_DATA_W-1:0] recip);
    write_reg(CFG_WINDOW_SIZE, size);
    write_reg(CFG_WINDOW_RECIP, recip);
  endtask

  initial begin : stimulus
    int ws;
    clear_histories();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // directed: field extremes, bit patterns, back-to-back record ends
    set_traffic(TX_STREAM, RX_FREE);
    queue_sample('0, 1'b0);
    repeat (3) queue_sample(12'sd2047, 1'b0);
    repeat (3) queue_sample(-12'sd2048, 1'b0);
    queue_sample(-12'sd1, 1'b0);
    queue_sample(12'sd1, 1'b0);
    queue_sample(12'h555, 1'b0);
    queue_sample(12'hAAA, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(12'sd2047, 1'b1);
    queue_sample(-12'sd2048, 1'b1);
    repeat (4) queue_sample(12'sd2047, 1'b0);
    queue_sample('0, 1'b1);
    queue_sample(-12'sd2048, 1'b0);
    wait_drained();

    // reset window settings
    set_traffic(TX_BURSTY, RX_RANDOM);
    queue_mix(200, 1'b0);
    wait_drained();

    // single-tap window, long output hold, then a sender pause
    set_window(16'd1, 16'hFFFF);
    set_traffic(TX_STREAM, RX_PATTERN);
    queue_mix(130, 1'b0);
    hold_token++;
    while (sample_backlog.size() > 50) @(posedge clk_i);
    sender_hold = 1'b1;
    while (predicted.size() != 0) @(posedge clk_i);
    sender_hold = 1'b0;
    wait_drained();

    set_window(16'd64, 16'd1024);
    set_traffic(TX_STREAM, RX_FREE);
    queue_mix(120, 1'b0);
    wait_drained();

    // zero window size acts as one
    set_window(16'd0, 16'h8000);
    set_traffic(TX_BURSTY, RX_PATTERN);
    queue_mix(100, 1'b0);
    wait_drained();

    // oversize window clips to the maximum; loud square waves
    set_window(16'hFFFF, 16'hFFFF);
    set_traffic(TX_BURSTY, RX_RANDOM);
    queue_mix(100, 1'b1);
    wait_drained();

    repeat (3) begin
      ws = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      case ($urandom_range(0, 2))
        0:       set_window(CFG_DATA_W'(ws),
                            (ws >= 64) ? 16'd1024 : CFG_DATA_W'(65536 / ws));
        1:       set_window(CFG_DATA_W'(ws), CFG_DATA_W'($urandom_range(0, 65535)));
        default: set_window(CFG_DATA_W'(ws), 16'd0);
      endcase
      set_traffic(tx_mode_e'($urandom_range(0, 1)), rx_mode_e'($urandom_range(0, 2)));
      queue_mix(80, 1'b0);
      wait_drained();
    end

    if (predicted.size() != 0) mismatches++;
    $display("Ran %0d samples (%0d record ends) and checked %0d results", beats_in,
             record_ends, beats_out);
    $display("across %0d register writes; %0d field mismatches", reg_writes, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
